>>> sv/drrip_replacement_policy_defines.svh
// ----------------------------------------------------------------------------
// DRRIP replacement policy assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DRRIP_REPLACEMENT_POLICY_DEFINES_SVH
`define DRRIP_REPLACEMENT_POLICY_DEFINES_SVH

// Checks that the property holds at every rising edge outside of reset.
`define DRRIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the expression is never true outside of reset.
`define DRRIP_ASSERT_NEVER(lbl, expr, msg) \
  `DRRIP_ASSERT(lbl, !(expr), msg)

`endif

>>> sv/drrip_pkg.sv
// ----------------------------------------------------------------------------
// DRRIP package
// Geometry, field widths and shared types of the DRRIP replacement policy.
// ----------------------------------------------------------------------------
package drrip_pkg;

  // Cache geometry and counter widths.
  localparam int unsigned NumSets   = 2048;
  localparam int unsigned NumWays   = 16;
  localparam int unsigned RrpvWidth = 2;
  localparam int unsigned SelWidth  = 10;

  // Fixed widths of the transaction fields.
  localparam int unsigned SetFieldW = 11;
  localparam int unsigned WayFieldW = 4;
  localparam int unsigned VictimW   = 4;

  // Set dueling: the low bits of the set index pick the leader sets.
  localparam int unsigned LeaderW  = 5;
  localparam int unsigned BimodalW = 5;
  localparam logic [LeaderW-1:0] SrripLeader = LeaderW'(0);
  localparam logic [LeaderW-1:0] BrripLeader = LeaderW'(1);

  // Derived widths and values.
  localparam int unsigned SetW = $clog2(NumSets);
  localparam int unsigned WayW = $clog2(NumWays);
  localparam int unsigned RowW = NumWays * RrpvWidth;

  localparam logic [RrpvWidth-1:0] RrpvTop = {RrpvWidth{1'b1}};
  localparam logic [SelWidth-1:0]  SelTop  = {SelWidth{1'b1}};
  localparam logic [SelWidth-1:0]  SelMid  = SelTop >> 1;

  // Function codes of an input transaction.
  typedef enum logic {
    FuncVictim = 1'b0,
    FuncUpdate = 1'b1
  } func_e;

  typedef logic [NumWays-1:0][RrpvWidth-1:0] row_t;

endpackage

>>> sv/drrip_ram.sv
// ----------------------------------------------------------------------------
// DRRIP generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module drrip_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/drrip_replacement_policy.sv
// ----------------------------------------------------------------------------
// DRRIP replacement policy
// Timing: an accepted transaction reads its set row from the RRPV memory;
// the modify step then writes it back and registers valid_o for a query.
// A new transaction is taken only after the read-modify-write of one set
// row in the RRPV memory completes (busy is high meanwhile); the
// receiver cannot stall, so nothing else holds the flow.
// Reset: a clearing pass over all 2048 rows fills every row with the maximum RRPV.
// ----------------------------------------------------------------------------
`include "drrip_replacement_policy_defines.svh"

module drrip_replacement_policy (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func_i,
  input  logic [drrip_pkg::SetFieldW-1:0] set_index_i,
  input  logic [drrip_pkg::WayFieldW-1:0] way_i,
  input  logic                            hit_i,
  output logic                            valid_o,
  output logic [drrip_pkg::VictimW-1:0]   victim_way_o
);

  // Controller states. After reset the block sweeps the memory, then waits
  // in idle for a transaction and then passes through the read-modify-write
  // state, where the row read at accept time comes out of the memory.
  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StRmw   = 2'd2;

  logic [1:0] state_q, state_d;

  // Transaction fields held across the read cycle.
  logic                            func_q;
  logic [drrip_pkg::SetW-1:0]      set_q;
  logic [drrip_pkg::WayFieldW-1:0] way_q;
  logic                            hit_q;

  // Clearing pass address.
  logic [drrip_pkg::SetW-1:0] clr_q, clr_d;

  // Set dueling selector and the BRRIP insertion counter.
  logic [drrip_pkg::SelWidth-1:0] sel_q, sel_d;
  logic [drrip_pkg::BimodalW-1:0] bim_q, bim_d;

  // Result register.
  logic                          valid_q;
  logic [drrip_pkg::VictimW-1:0] victim_q;

  // Memory ports.
  logic                       accept;
  logic                       ram_we;
  logic [drrip_pkg::SetW-1:0] ram_waddr;
  logic [drrip_pkg::SetW-1:0] raddr;
  drrip_pkg::row_t            ram_wdata;
  drrip_pkg::row_t            rd_row;

  // Datapath of the modify step.
  logic [drrip_pkg::SetW+drrip_pkg::SetFieldW-1:0] set_ext;
  logic [drrip_pkg::WayW+drrip_pkg::WayFieldW-1:0] way_ext;
  logic [drrip_pkg::WayW-1:0]                      way_idx;
  logic                                            way_ok;
  logic [drrip_pkg::RrpvWidth-1:0]                 row_max;
  logic [drrip_pkg::RrpvWidth-1:0]                 lift;
  drrip_pkg::row_t                                 aged_row;
  drrip_pkg::row_t                                 upd_row;
  logic [drrip_pkg::WayW+drrip_pkg::VictimW-1:0]   victim_ext;
  logic [drrip_pkg::WayW-1:0]                      victim_idx;
  logic                                            s_lead;
  logic                                            b_lead;
  logic                                            use_b;
  logic [drrip_pkg::BimodalW-1:0]                  bim_next;
  logic [drrip_pkg::RrpvWidth-1:0]                 ins_val;
  logic                                            do_insert;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // The set index is taken modulo the number of sets; zero extension first
  // keeps this correct whether the set count is above or below the field.
  assign set_ext = {{drrip_pkg::SetW{1'b0}}, set_index_i};
  assign raddr   = set_ext[drrip_pkg::SetW-1:0];

  // A way beyond the cache's associativity leaves the memory, selector and counter as is.
  assign way_ext = {{drrip_pkg::WayW{1'b0}}, way_q};
  assign way_idx = way_ext[drrip_pkg::WayW-1:0];
  assign way_ok  = (way_ext < (drrip_pkg::WayW + drrip_pkg::WayFieldW)'(drrip_pkg::NumWays));

  drrip_ram #(
    .Width(drrip_pkg::RowW),
    .Depth(drrip_pkg::NumSets)
  ) u_rrpv_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(raddr),
    .rdata_o(rd_row)
  );

  // Victim search. Raising every way by the gap between the largest value
  // and the maximum moves the oldest ways to the maximum, so the victim is
  // the lowest way that already holds the largest value of the row.
  always_comb begin
    row_max    = '0;
    victim_idx = '0;
    for (int w = 0; w < drrip_pkg::NumWays; w++) begin
      if (rd_row[w] > row_max) begin
        row_max = rd_row[w];
      end
    end
    lift = drrip_pkg::RrpvTop - row_max;
    for (int w = 0; w < drrip_pkg::NumWays; w++) begin
      aged_row[w] = rd_row[w] + lift;
    end
    for (int w = drrip_pkg::NumWays - 1; w >= 0; w--) begin
      if (rd_row[w] == row_max) begin
        victim_idx = drrip_pkg::WayW'(w);
      end
    end
  end

  // The output field is four bits wide whatever the associativity.
  assign victim_ext = {{drrip_pkg::VictimW{1'b0}}, victim_idx};

  // Insertion policy. Leader sets fix their own policy; followers take BRRIP
  // while the selector is at or above its midpoint. Only the leaders move
  // the selector, so the followers see the same value before and after.
  assign s_lead    = (set_q[drrip_pkg::LeaderW-1:0] == drrip_pkg::SrripLeader);
  assign b_lead    = (set_q[drrip_pkg::LeaderW-1:0] == drrip_pkg::BrripLeader);
  assign use_b     = b_lead || (!s_lead && (sel_q >= drrip_pkg::SelMid));
  assign bim_next  = bim_q + drrip_pkg::BimodalW'(1);
  assign do_insert = (state_q == StRmw) && (func_q == drrip_pkg::FuncUpdate) &&
                     !hit_q && way_ok;

  // BRRIP inserts at the maximum except when its counter wraps to zero.
  always_comb begin
    if (use_b && (bim_next != '0)) begin
      ins_val = drrip_pkg::RrpvTop;
    end else begin
      ins_val = drrip_pkg::RrpvTop - drrip_pkg::RrpvWidth'(1);
    end
  end

  always_comb begin
    upd_row = rd_row;
    if (hit_q) begin
      upd_row[way_idx] = '0;
    end else begin
      upd_row[way_idx] = ins_val;
    end
  end

  always_comb begin
    sel_d = sel_q;
    bim_d = bim_q;
    if (do_insert) begin
      if (s_lead && (sel_q != drrip_pkg::SelTop)) begin
        sel_d = sel_q + drrip_pkg::SelWidth'(1);
      end else if (b_lead && (sel_q != '0)) begin
        sel_d = sel_q - drrip_pkg::SelWidth'(1);
      end
      if (use_b) begin
        bim_d = bim_next;
      end
    end
  end

  // Memory write side: the clearing pass owns the port until it is done,
  // afterwards only the modify step writes. A query writes back the aged
  // row; an update writes only when the way is in range.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = aged_row;
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        // All ones is the maximum RRPV in every way.
        ram_wdata = '1;
      end
      StRmw: begin
        if (func_q == drrip_pkg::FuncVictim) begin
          ram_we    = 1'b1;
          ram_wdata = aged_row;
        end else begin
          ram_we    = way_ok;
          ram_wdata = upd_row;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Controller. A transaction accepted in idle reads its row at once; the
  // row is ready in the following cycle, which writes it back and returns
  // to idle. No two accesses to a row can overlap, so no forwarding is needed.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + drrip_pkg::SetW'(1);
        if (clr_q == {drrip_pkg::SetW{1'b1}}) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StRmw;
        end
      end
      StRmw: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      sel_q   <= drrip_pkg::SelMid;
      bim_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sel_q   <= sel_d;
      bim_q   <= bim_d;
      valid_q <= (state_q == StRmw) && (func_q == drrip_pkg::FuncVictim);
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      set_q  <= raddr;
      way_q  <= way_i;
      hit_q  <= hit_i;
    end
    if (state_q == StRmw) begin
      victim_q <= victim_ext[drrip_pkg::VictimW-1:0];
    end
  end

  assign valid_o      = valid_q;
  assign victim_way_o = victim_q;

  // A result follows only a query's modify step.
  `DRRIP_ASSERT(a_valid_from_query,
                valid_o |-> $past(state_q == StRmw && func_q == drrip_pkg::FuncVictim),
                "result strobe without a victim query")
  // An accepted transaction always moves on to the modify step.
  `DRRIP_ASSERT(a_accept_to_rmw, accept |=> (state_q == StRmw),
                "accepted transaction did not reach the modify step")
  // The memory is never written while the block waits for work.
  `DRRIP_ASSERT_NEVER(a_no_idle_write, ram_we && (state_q == StIdle),
                      "memory write while idle")

endmodule

>>> tb/drrip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DRRIP replacement policy checker
// Watches the command and result channels of the replacement policy, keeps
// its own copy of the re-reference values, selector and bimodal counter, and
// compares every victim result with the oldest outstanding query.
// ----------------------------------------------------------------------------
module drrip_checker
  import drrip_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 func_i,
  input  logic [SetFieldW-1:0] set_index_i,
  input  logic [WayFieldW-1:0] way_i,
  input  logic                 hit_i,
  input  logic                 valid_i,
  input  logic [VictimW-1:0]   victim_way_i,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          errors_o
);

  row_t                rrpv_rows [NumSets];
  logic [SelWidth-1:0] policy_sel;
  logic [BimodalW-1:0] brrip_count;
  logic [VictimW-1:0]  victim_queue [$];
  logic [VictimW-1:0]  want_way;

  task automatic report_mismatch(input string what);
    $display("[%0t] drrip_checker: %s", $time, what);
    errors_o++;
  endtask

  // Ages the set so that its largest value reaches the top, writes the aged
  // row back and returns the lowest way that holds the top value.
  function automatic logic [VictimW-1:0] age_and_pick(input logic [SetW-1:0] s);
    row_t                 row;
    logic [RrpvWidth-1:0] top_v;
    logic [RrpvWidth-1:0] lift;
    logic [VictimW-1:0]   pick;
    logic                 found;
    row   = rrpv_rows[s];
    top_v = '0;
    pick  = '0;
    found = 1'b0;
    for (int w = 0; w < NumWays; w++) begin
      if (row[w] > top_v) top_v = row[w];
    end
    lift = RrpvTop - top_v;
    for (int w = 0; w < NumWays; w++) begin
      row[w] = row[w] + lift;
      if (!found && row[w] == RrpvTop) begin
        pick  = VictimW'(w);
        found = 1'b1;
      end
    end
    rrpv_rows[s] = row;
    return pick;
  endfunction

  // Hit promotion or miss insertion, with set dueling on the leader sets.
  function automatic void apply_reference(input logic [SetW-1:0] s,
                                          input logic [WayFieldW-1:0] w,
                                          input logic was_hit);
    logic s_lead;
    logic b_lead;
    logic pick_bimodal;
    if (w >= NumWays) return;
    if (was_hit) begin
      rrpv_rows[s][w] = '0;
      return;
    end
    s_lead = (s[LeaderW-1:0] == SrripLeader);
    b_lead = (s[LeaderW-1:0] == BrripLeader);
    if (s_lead && policy_sel != SelTop) policy_sel = policy_sel + 1'b1;
    if (b_lead && policy_sel != '0) policy_sel = policy_sel - 1'b1;
    if (s_lead) pick_bimodal = 1'b0;
    else if (b_lead) pick_bimodal = 1'b1;
    else pick_bimodal = (policy_sel >= SelMid);
    if (!pick_bimodal) begin
      rrpv_rows[s][w] = RrpvTop - 1'b1;
    end else begin
      brrip_count = brrip_count + 1'b1;
      rrpv_rows[s][w] = (brrip_count == '0) ? RrpvTop - 1'b1 : RrpvTop;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSets; s++) rrpv_rows[s] = '1;
      policy_sel  = SelMid;
      brrip_count = '0;
      victim_queue.delete();
      pending_o   = 0;
      checked_o   = 0;
      errors_o    = 0;
    end else begin
      // A result at this edge belongs to an earlier query, so it is matched
      // before a query accepted at the same edge is queued.
      if (valid_i === 1'b1) begin
        if (victim_queue.size() == 0) begin
          report_mismatch($sformatf("victim way %0d with no query outstanding",
                                    victim_way_i));
        end else begin
          want_way = victim_queue.pop_front();
          checked_o++;
          if (victim_way_i !== want_way) begin
            report_mismatch($sformatf("victim way %0d, expected %0d",
                                      victim_way_i, want_way));
          end
        end
      end else if (valid_i !== 1'b0) begin
        report_mismatch("result strobe is unknown");
      end
      if (start_i && !busy_i) begin
        if (func_i == FuncVictim) begin
          victim_queue.push_back(age_and_pick(set_index_i[SetW-1:0]));
        end else begin
          apply_reference(set_index_i[SetW-1:0], way_i, hit_i);
        end
      end
      pending_o = victim_queue.size();
    end
  end

endmodule

>>> tb/tb_drrip_replacement_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DRRIP replacement policy testbench
// Drives directed and random victim queries, hits and miss insertions into
// the replacement policy with random idle gaps, and lets the checker predict
// and compare every victim result.
// ----------------------------------------------------------------------------
module tb_drrip_replacement_policy;
  import drrip_pkg::*;

  localparam int unsigned RandomItems = 750;
  localparam int unsigned HotSlots    = 8;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 func_i;
  logic [SetFieldW-1:0] set_index_i;
  logic [WayFieldW-1:0] way_i;
  logic                 hit_i;
  logic                 valid_o;
  logic [VictimW-1:0]   victim_way_o;

  int unsigned pending_victims;
  int unsigned checked_victims;
  int unsigned mismatches;

  // Statistics for the closing summary.
  int unsigned sent_queries;
  int unsigned sent_hits;
  int unsigned sent_misses;
  int unsigned random_sent;

  // When set, the sender issues transactions back to back.
  logic steady;

  // A small pool of sets that most random traffic goes to, so that rows get
  // reused, aged and refilled instead of staying at their reset value.
  logic [SetFieldW-1:0] hot_sets [HotSlots];

  drrip_replacement_policy u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .set_index_i  (set_index_i),
    .way_i        (way_i),
    .hit_i        (hit_i),
    .valid_o      (valid_o),
    .victim_way_o (victim_way_o)
  );

  drrip_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .func_i       (func_i),
    .set_index_i  (set_index_i),
    .way_i        (way_i),
    .hit_i        (hit_i),
    .valid_i      (valid_o),
    .victim_way_i (victim_way_o),
    .pending_o    (pending_victims),
    .checked_o    (checked_victims),
    .errors_o     (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: the slowest correct run (clearing pass plus every transaction
  // waiting out the longest gap) stays far below this.
  initial begin
    #200000;
    $display("tb_drrip_replacement_policy NOT OK");
    $finish;
  end

  // Sends one transaction. A random idle gap, possibly none, comes first unless
  // the sender is in a steady stretch. Inputs change on the falling edge and
  // the transaction is accepted at the first rising edge with busy low. When
  // there is no gap, start simply stays high into the next transaction.
  task automatic send_item(input func_e f, input logic [SetFieldW-1:0] s,
                           input logic [WayFieldW-1:0] w, input logic h);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start       <= 1'b1;
    func_i      <= f;
    set_index_i <= s;
    way_i       <= w;
    hit_i       <= h;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (f == FuncVictim) sent_queries++;
    else if (h) sent_hits++;
    else sent_misses++;
  endtask

  // Lowers start and holds off until every outstanding query has returned.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    wait (pending_victims == 0);
  endtask

  // Refills the pool of hot sets. The leader slots lean toward one kind of
  // leader so that the selector drifts across its midpoint in both
  // directions over the run, switching the followers between policies.
  task automatic refill_hot_sets(input logic favor_srrip);
    logic [LeaderW-1:0] major;
    logic [LeaderW-1:0] minor;
    major = favor_srrip ? SrripLeader : BrripLeader;
    minor = favor_srrip ? BrripLeader : SrripLeader;
    hot_sets[0] = {6'($urandom_range(0, 63)), major};
    hot_sets[1] = {6'($urandom_range(0, 63)), major};
    hot_sets[2] = {6'($urandom_range(0, 63)), major};
    hot_sets[3] = {6'($urandom_range(0, 63)), minor};
    for (int k = 4; k < HotSlots; k++) hot_sets[k] = SetFieldW'($urandom);
  endtask

  initial begin
    logic [SetFieldW-1:0] s;
    logic [WayFieldW-1:0] w;
    int unsigned          pick;
    logic                 favor_srrip;
    logic                 drained;

    // Every input is known from time zero; reset is asserted from time zero.
    rst_ni      = 1'b0;
    start       = 1'b0;
    func_i      = FuncVictim;
    set_index_i = '0;
    way_i       = '0;
    hit_i       = 1'b0;
    steady      = 1'b0;
    sent_queries = 0;
    sent_hits    = 0;
    sent_misses  = 0;
    random_sent  = 0;
    favor_srrip  = 1'b0;
    drained      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---------------- Directed part ----------------
    // The first transaction also waits out the clearing pass, since busy
    // stays high until every row holds the maximum value.
    // A fresh set: all ways at the top, so way 0 is the victim.
    send_item(FuncVictim, 11'h7FF, 4'd0, 1'b0);
    // A hit on way 0 pushes the victim to way 1.
    send_item(FuncUpdate, 11'd3, 4'd0, 1'b1);
    send_item(FuncVictim, 11'd3, 4'd0, 1'b0);
    // Miss in an SRRIP leader (selector up) and in a BRRIP leader (down).
    send_item(FuncUpdate, 11'd0, 4'd15, 1'b0);
    send_item(FuncUpdate, 11'd1, 4'd7, 1'b0);
    // A BRRIP leader miss leaves the selector below its midpoint, so this
    // follower miss inserts with SRRIP.
    send_item(FuncUpdate, 11'd1, 4'd8, 1'b0);
    send_item(FuncUpdate, 11'd2, 4'd0, 1'b0);
    send_item(FuncVictim, 11'd2, 4'd0, 1'b0);
    // Back at the midpoint, followers switch to BRRIP.
    send_item(FuncUpdate, 11'd32, 4'd3, 1'b0);
    send_item(FuncUpdate, 11'd34, 4'd9, 1'b0);
    send_item(FuncVictim, 11'd34, 4'd0, 1'b0);
    send_item(FuncVictim, 11'd0, 4'd0, 1'b0);
    send_item(FuncVictim, 11'd1, 4'd0, 1'b0);
    // Victim on way 15: hit every other way of one set. Ways 0 to 14 drop to
    // zero, way 15 stays at the top and no aging is needed.
    steady = 1'b1;
    for (int k = 0; k < 15; k++) send_item(FuncUpdate, 11'h555, WayFieldW'(k), 1'b1);
    steady = 1'b0;
    send_item(FuncVictim, 11'h555, 4'd15, 1'b0);
    // Now all ways are zero: the query lifts the whole row by the full range.
    send_item(FuncUpdate, 11'h555, 4'd15, 1'b1);
    send_item(FuncVictim, 11'h555, 4'd0, 1'b0);

    // ---------------- Random part ----------------
    refill_hot_sets(favor_srrip);
    while (random_sent < RandomItems) begin
      // Every so often the pool and the sender's pacing change.
      if (random_sent % 60 == 0) begin
        if (random_sent % 180 == 0) favor_srrip = ~favor_srrip;
        refill_hot_sets(favor_srrip);
        steady = ($urandom_range(0, 3) == 0);
      end
      // Halfway through, the sender stops until every result is back.
      if (!drained && random_sent >= RandomItems / 2) begin
        drain_results();
        drained = 1'b1;
      end

      pick = $urandom_range(0, 99);
      s = (pick < 75) ? hot_sets[$urandom_range(0, HotSlots - 1)]
                      : SetFieldW'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // Touch every way of one set, then query it: the row goes all low
        // and the query has to age it all the way up.
        for (int k = 0; k < NumWays; k++) begin
          send_item(FuncUpdate, s, WayFieldW'(k), 1'b1);
        end
        send_item(FuncVictim, s, WayFieldW'($urandom), 1'b0);
        random_sent += NumWays + 1;
      end else if (pick < 40) begin
        // A cache miss as the cache sees it: query, then fill a way.
        send_item(FuncVictim, s, WayFieldW'($urandom), 1'b0);
        send_item(FuncUpdate, s, WayFieldW'($urandom), 1'b0);
        random_sent += 2;
      end else begin
        w = WayFieldW'($urandom);
        send_item(func_e'($urandom_range(0, 1)), s, w, 1'($urandom_range(0, 1)));
        random_sent++;
      end
    end

    // ---------------- Wind-down ----------------
    drain_results();
    repeat (6) @(posedge clk_i);

    $display("Sent %0d transactions: %0d victim queries, %0d hits, %0d miss insertions.",
             sent_queries + sent_hits + sent_misses, sent_queries, sent_hits, sent_misses);
    $display("Compared %0d victim results, %0d mismatches.", checked_victims, mismatches);
    if (mismatches == 0) begin
      $display("tb_drrip_replacement_policy OK");
    end else begin
      $display("tb_drrip_replacement_policy NOT OK");
    end
    $finish;
  end

endmodule
